FILE: rtl/core/http_request_stream_parser_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef HTTP_REQUEST_STREAM_PARSER_MACROS_SVH
`define HTTP_REQUEST_STREAM_PARSER_MACROS_SVH

// Check a property while the block is out of reset.
`define HRSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define HRSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/core/hrsp_pkg.sv
package hrsp_pkg;

    localparam int DEF_MAX_HEADERS = 32;
    localparam int DEF_MAX_PARAMS  = 16;
    localparam int DEF_OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int MAX_RECS        = 3;

    typedef enum logic [3:0] {
        KIND_METHOD    = 4'd0,
        KIND_PATH      = 4'd1,
        KIND_QUERY     = 4'd2,
        KIND_VERSION   = 4'd3,
        KIND_HDR_KEY   = 4'd4,
        KIND_HDR_VALUE = 4'd5,
        KIND_PRM_KEY   = 4'd6,
        KIND_PRM_VALUE = 4'd7,
        KIND_HDRS_DONE = 4'd8,
        KIND_BODY      = 4'd9,
        KIND_DONE      = 4'd10,
        KIND_ERROR     = 4'd11
    } kind_t;

    typedef enum logic [3:0] {
        PH_METHOD   = 4'd0,
        PH_PRE_PATH = 4'd1,
        PH_PATH     = 4'd2,
        PH_Q_PEND   = 4'd3,
        PH_Q_KEY    = 4'd4,
        PH_Q_VAL    = 4'd5,
        PH_Q_SKIP   = 4'd6,
        PH_PRE_VER  = 4'd7,
        PH_VERSION  = 4'd8,
        PH_LINE     = 4'd9,
        PH_H_KEY    = 4'd10,
        PH_H_LEAD   = 4'd11,
        PH_H_VALUE  = 4'd12,
        PH_H_DROP   = 4'd13,
        PH_BODY     = 4'd14,
        PH_DONE     = 4'd15
    } phase_t;

    // value matcher codes
    localparam logic [3:0] NM_NONE    = 4'd0;
    localparam logic [3:0] NM_CLEN    = 4'd1;
    localparam logic [3:0] NM_CONN    = 4'd2;
    localparam logic [3:0] NM_CLOSE   = 4'd3;
    localparam logic [3:0] NM_KEEP    = 4'd4;
    localparam logic [3:0] NM_EXPECT  = 4'd5;
    localparam logic [3:0] NM_VERSION = 4'd1;
    localparam logic [3:0] NM_ALL     = 4'd7;

    // flag bit positions
    localparam int FL_KEEP    = 0;
    localparam int FL_EXPECT  = 1;
    localparam int FL_REFUSED = 2;
    localparam int FL_HTRUNC  = 3;
    localparam int FL_PTRUNC  = 4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_AMP   = 8'h26;

    localparam logic [127:0] TXT_CLEN   = 128'("content-length");
    localparam logic [127:0] TXT_CONN   = 128'("connection");
    localparam logic [127:0] TXT_EXPECT = 128'("expect");
    localparam logic [127:0] TXT_HTTP10 = 128'("HTTP/1.0");
    localparam logic [127:0] TXT_CLOSE  = 128'("close");
    localparam logic [127:0] TXT_KEEP   = 128'("keep-alive");
    localparam logic [127:0] TXT_CONT   = 128'("100-continue");

    localparam logic [3:0] LEN_CLEN   = 4'd14;
    localparam logic [3:0] LEN_CONN   = 4'd10;
    localparam logic [3:0] LEN_EXPECT = 4'd6;
    localparam logic [3:0] LEN_HTTP10 = 4'd8;
    localparam logic [3:0] LEN_CLOSE  = 4'd5;
    localparam logic [3:0] LEN_KEEP   = 4'd10;
    localparam logic [3:0] LEN_CONT   = 4'd12;

    typedef struct packed {
        kind_t        kind;
        logic [15:0]  off;
        logic [15:0]  len;
        logic [5:0]   idx;
        logic [31:0]  clen;
        logic [4:0]   flags;
    } rec_t;

    typedef struct packed {
        rec_t [MAX_RECS-1:0] recs;
        logic [1:0]          n;
    } bundle_t;

    // Character k of a text of n characters held in the low bytes of t.
    function automatic logic [7:0] txt_at(logic [127:0] t, logic [3:0] n, logic [3:0] k);
        logic [3:0] i;
        i = n - k - 4'd1;
        return t[{i, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] to_lower(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

FILE: rtl/core/hrsp_queue.sv
module hrsp_queue
    import hrsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output bundle_t head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/hrsp_front.sv
module hrsp_front
    import hrsp_pkg::*;
#(
    parameter int MAX_HEADERS = DEF_MAX_HEADERS,
    parameter int MAX_PARAMS  = DEF_MAX_PARAMS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        in_restart,
    output logic        in_ready,
    input  logic [30:0] max_size,
    input  logic        q_full,
    output logic        q_push,
    output bundle_t     q_data
);
    localparam int POS_W = OFFSET_BITS + 1;
    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        phase_t      phase;
        pos_t        byte_offset;
        pos_t        slice_start;
        pos_t        query_start;
        logic        saw_cr;
        logic [6:0]  header_count;
        logic [5:0]  param_count;
        logic [3:0]  name_match;
        logic [3:0]  match_pos;
        logic [31:0] length_accum;
        logic [31:0] body_left;
        logic [4:0]  flags;
    } prs_state_t;

    typedef struct packed {
        prs_state_t st;
        bundle_t    b;
    } work_t;

    localparam prs_state_t ST_RESET = '{
        phase: PH_METHOD, byte_offset: '0, slice_start: '0, query_start: '0,
        saw_cr: 1'b0, header_count: '0, param_count: '0, name_match: NM_NONE,
        match_pos: '0, length_accum: '1, body_left: '0, flags: 5'b00001
    };

    prs_state_t state_reg, state_next;
    bundle_t    out_b;

    function automatic logic [15:0] lo16(pos_t v);
        logic [POS_W+15:0] t;
        t = {16'd0, v};
        return t[15:0];
    endfunction

    function automatic bundle_t add_rec(bundle_t b, kind_t k, pos_t off, pos_t len,
                                        logic [6:0] idx, logic [31:0] clen,
                                        logic [4:0] fl);
        rec_t r;
        r.kind  = k;
        r.off   = lo16(off);
        r.len   = lo16(len);
        r.idx   = idx[5:0];
        r.clen  = clen;
        r.flags = fl;
        if (b.n != 2'(MAX_RECS)) begin
            b.recs[b.n] = r;
            b.n         = b.n + 2'd1;
        end
        return b;
    endfunction

    function automatic prs_state_t match_text(prs_state_t s, logic [127:0] t, logic [3:0] n,
                                              logic [7:0] ch, logic [4:0] fset,
                                              logic [4:0] fclr);
        if (s.match_pos < n && ch == txt_at(t, n, s.match_pos)) begin
            s.match_pos = s.match_pos + 4'd1;
            if (s.match_pos == n) begin
                s.flags      = (s.flags | fset) & ~fclr;
                s.name_match = NM_NONE;
            end
        end else begin
            s.name_match = NM_NONE;
        end
        return s;
    endfunction

    // One pass of the line parser over one character.
    function automatic work_t proc(work_t w, logic [7:0] c, pos_t pos, pos_t lend,
                                   logic [30:0] msize);
        prs_state_t  s;
        bundle_t     b;
        logic [7:0]  lc;
        logic [3:0]  m;
        pos_t        e;
        logic [34:0] v;
        logic        body;
        s  = w.st;
        b  = w.b;
        lc = to_lower(c);
        e  = (c == CH_SP) ? pos : lend;
        // a byte that opens a field falls through into the field's phase
        if (s.phase == PH_PRE_PATH && c != CH_SP && c != CH_LF) begin
            s.slice_start = pos;
            s.phase       = PH_PATH;
        end
        if (s.phase == PH_PRE_VER && c != CH_SP && c != CH_LF) begin
            s.slice_start = pos;
            s.name_match  = NM_VERSION;
            s.match_pos   = '0;
            s.phase       = PH_VERSION;
        end
        if (s.phase == PH_LINE && c != CH_LF) begin
            s.slice_start = pos;
            s.name_match  = NM_ALL;
            s.match_pos   = '0;
            s.phase       = PH_H_KEY;
        end
        if (s.phase == PH_H_LEAD && c != CH_SP && c != CH_TAB && c != CH_LF) begin
            s.slice_start = pos;
            s.phase       = PH_H_VALUE;
        end
        case (s.phase)
            PH_METHOD: begin
                if (c == CH_SP) begin
                    b = add_rec(b, KIND_METHOD, s.slice_start, pos - s.slice_start, '0,
                                s.length_accum, s.flags);
                    s.phase = PH_PRE_PATH;
                end else if (c == CH_LF) begin
                    b = add_rec(b, KIND_ERROR, pos, '0, '0, s.length_accum, s.flags);
                    s.phase = PH_DONE;
                end
            end
            PH_PRE_PATH: begin
                if (c == CH_LF) begin
                    b = add_rec(b, KIND_PATH, lend, '0, '0, s.length_accum, s.flags);
                    s.phase = PH_LINE;
                end
            end
            PH_PATH: begin
                if (c == CH_SP || c == CH_QUES) begin
                    b = add_rec(b, KIND_PATH, s.slice_start, pos - s.slice_start, '0,
                                s.length_accum, s.flags);
                    if (c == CH_QUES) begin
                        s.query_start = pos + 1'b1;
                        s.phase       = PH_Q_PEND;
                    end else begin
                        s.phase = PH_PRE_VER;
                    end
                end else if (c == CH_LF) begin
                    b = add_rec(b, KIND_PATH, s.slice_start, lend - s.slice_start, '0,
                                s.length_accum, s.flags);
                    s.phase = PH_LINE;
                end
            end
            PH_Q_PEND, PH_Q_KEY, PH_Q_VAL, PH_Q_SKIP: begin
                if (c == CH_SP || c == CH_LF) begin
                    // close the open parameter, then the whole query
                    if (s.phase == PH_Q_KEY) begin
                        b = add_rec(b, KIND_PRM_KEY, s.slice_start, e - s.slice_start,
                                    {1'b0, s.param_count}, s.length_accum, s.flags);
                        b = add_rec(b, KIND_PRM_VALUE, e, '0, {1'b0, s.param_count},
                                    s.length_accum, s.flags);
                        s.param_count = s.param_count + 6'd1;
                    end else if (s.phase == PH_Q_VAL) begin
                        b = add_rec(b, KIND_PRM_VALUE, s.slice_start, e - s.slice_start,
                                    {1'b0, s.param_count}, s.length_accum, s.flags);
                        s.param_count = s.param_count + 6'd1;
                    end
                    b = add_rec(b, KIND_QUERY, s.query_start, e - s.query_start, '0,
                                s.length_accum, s.flags);
                    s.phase = (c == CH_SP) ? PH_PRE_VER : PH_LINE;
                end else begin
                    if (s.phase == PH_Q_PEND) begin
                        if (s.param_count >= 6'(MAX_PARAMS)) begin
                            s.flags[FL_PTRUNC] = 1'b1;
                            s.phase            = PH_Q_SKIP;
                        end else begin
                            s.slice_start = pos;
                            s.phase       = PH_Q_KEY;
                        end
                    end
                    if (s.phase == PH_Q_KEY) begin
                        if (c == CH_EQ) begin
                            b = add_rec(b, KIND_PRM_KEY, s.slice_start, pos - s.slice_start,
                                        {1'b0, s.param_count}, s.length_accum, s.flags);
                            s.slice_start = pos + 1'b1;
                            s.phase       = PH_Q_VAL;
                        end else if (c == CH_AMP) begin
                            b = add_rec(b, KIND_PRM_KEY, s.slice_start, pos - s.slice_start,
                                        {1'b0, s.param_count}, s.length_accum, s.flags);
                            b = add_rec(b, KIND_PRM_VALUE, pos, '0, {1'b0, s.param_count},
                                        s.length_accum, s.flags);
                            s.param_count = s.param_count + 6'd1;
                            s.phase       = PH_Q_PEND;
                        end
                    end else if (s.phase == PH_Q_VAL && c == CH_AMP) begin
                        b = add_rec(b, KIND_PRM_VALUE, s.slice_start, pos - s.slice_start,
                                    {1'b0, s.param_count}, s.length_accum, s.flags);
                        s.param_count = s.param_count + 6'd1;
                        s.phase       = PH_Q_PEND;
                    end
                end
            end
            PH_PRE_VER: begin
                if (c == CH_LF) begin
                    b = add_rec(b, KIND_VERSION, lend, '0, '0, s.length_accum, s.flags);
                    s.phase = PH_LINE;
                end
            end
            PH_VERSION: begin
                if (c == CH_LF) begin
                    b = add_rec(b, KIND_VERSION, s.slice_start, lend - s.slice_start, '0,
                                s.length_accum, s.flags);
                    s.name_match = NM_NONE;
                    s.phase      = PH_LINE;
                end else if (s.name_match != NM_NONE) begin
                    s = match_text(s, TXT_HTTP10, LEN_HTTP10, c, 5'b0, 5'b00001);
                end
            end
            PH_LINE: begin
                if (c == CH_LF) begin
                    // blank line: settle the body
                    if (msize != '0 && !s.length_accum[31] &&
                        s.length_accum[30:0] > msize) begin
                        s.flags[FL_REFUSED] = 1'b1;
                        s.flags[FL_KEEP]    = 1'b0;
                    end
                    body = !s.length_accum[31] && s.length_accum != '0 &&
                           !s.flags[FL_REFUSED];
                    if (!body) begin
                        s.flags[FL_EXPECT] = 1'b0;
                    end
                    b = add_rec(b, KIND_HDRS_DONE, pos, '0, '0, s.length_accum, s.flags);
                    if (body) begin
                        s.body_left   = s.length_accum;
                        s.slice_start = pos + 1'b1;
                        s.phase       = PH_BODY;
                    end else begin
                        b = add_rec(b, KIND_DONE, pos, '0, '0, s.length_accum, s.flags);
                        s.phase = PH_DONE;
                    end
                end
            end
            PH_H_KEY: begin
                if (c == CH_COLON) begin
                    m = s.name_match;
                    if (s.header_count >= 7'(MAX_HEADERS)) begin
                        s.flags[FL_HTRUNC] = 1'b1;
                        s.name_match       = NM_NONE;
                        s.phase            = PH_H_DROP;
                    end else begin
                        b = add_rec(b, KIND_HDR_KEY, s.slice_start, pos - s.slice_start,
                                    s.header_count, s.length_accum, s.flags);
                        s.name_match = NM_NONE;
                        if (m[0] && s.match_pos == LEN_CLEN) begin
                            s.name_match   = NM_CLEN;
                            s.length_accum = '0;
                        end else if (m[1] && s.match_pos == LEN_CONN) begin
                            s.name_match = NM_CONN;
                        end else if (m[2] && s.match_pos == LEN_EXPECT) begin
                            s.name_match = NM_EXPECT;
                        end
                        s.match_pos = '0;
                        s.phase     = PH_H_LEAD;
                    end
                end else if (c == CH_LF) begin
                    b = add_rec(b, KIND_ERROR, pos, '0, '0, s.length_accum, s.flags);
                    s.phase = PH_DONE;
                end else begin
                    m = s.name_match;
                    if (s.match_pos >= LEN_CLEN || lc != txt_at(TXT_CLEN, LEN_CLEN, s.match_pos))
                        m[0] = 1'b0;
                    if (s.match_pos >= LEN_CONN || lc != txt_at(TXT_CONN, LEN_CONN, s.match_pos))
                        m[1] = 1'b0;
                    if (s.match_pos >= LEN_EXPECT ||
                        lc != txt_at(TXT_EXPECT, LEN_EXPECT, s.match_pos))
                        m[2] = 1'b0;
                    s.name_match = m;
                    if (s.match_pos != 4'd15) begin
                        s.match_pos = s.match_pos + 4'd1;
                    end
                end
            end
            PH_H_LEAD, PH_H_VALUE: begin
                if (c == CH_LF) begin
                    if (s.phase == PH_H_LEAD) begin
                        s.slice_start = lend;
                    end
                    b = add_rec(b, KIND_HDR_VALUE, s.slice_start, lend - s.slice_start,
                                s.header_count, s.length_accum, s.flags);
                    s.header_count = s.header_count + 7'd1;
                    s.name_match   = NM_NONE;
                    s.phase        = PH_LINE;
                end else if (s.phase == PH_H_VALUE) begin
                    case (s.name_match)
                        NM_CLEN: begin
                            if (s.match_pos == '0 &&
                                (c == CH_SP || (c >= CH_TAB && c <= CH_CR))) begin
                                s.match_pos = s.match_pos;
                            end else if (s.match_pos == '0 && c == CH_PLUS) begin
                                s.match_pos = 4'd1;
                            end else if (s.match_pos < 4'd2 && c >= 8'h30 && c <= 8'h39) begin
                                v = 35'({s.length_accum[30:0], 3'b000}) +
                                    35'({s.length_accum[30:0], 1'b0}) + 35'(c - 8'h30);
                                s.length_accum = (v[34:31] != '0) ? 32'h7FFF_FFFF
                                                                  : {1'b0, v[30:0]};
                                s.match_pos = 4'd1;
                            end else begin
                                s.match_pos = 4'd2;
                            end
                        end
                        NM_CONN: begin
                            s.name_match = (lc == 8'h63) ? NM_CLOSE :
                                           (lc == 8'h6B) ? NM_KEEP : NM_NONE;
                            s.match_pos  = 4'd1;
                        end
                        NM_CLOSE:  s = match_text(s, TXT_CLOSE, LEN_CLOSE, lc, 5'b0, 5'b00001);
                        NM_KEEP:   s = match_text(s, TXT_KEEP, LEN_KEEP, lc, 5'b00001, 5'b0);
                        NM_EXPECT: s = match_text(s, TXT_CONT, LEN_CONT, lc, 5'b00010, 5'b0);
                        default: ;
                    endcase
                end
            end
            PH_H_DROP: begin
                if (c == CH_LF) begin
                    s.phase = PH_LINE;
                end
            end
            default: ;
        endcase
        w.st = s;
        w.b  = b;
        return w;
    endfunction

    assign in_ready = !q_full;

    always_comb begin
        work_t       w;
        pos_t        pos;
        logic [31:0] left;
        w.st   = in_restart ? ST_RESET : state_reg;
        w.b    = '0;
        pos    = w.st.byte_offset;
        left   = '0;
        if (w.st.phase != PH_DONE) begin
            if (w.st.byte_offset[POS_W-1]) begin
                w.b = add_rec(w.b, KIND_ERROR, pos, '0, '0, w.st.length_accum, w.st.flags);
                w.st.phase  = PH_DONE;
                w.st.saw_cr = 1'b0;
            end else begin
                w.st.byte_offset = pos + 1'b1;
                if (w.st.phase == PH_BODY) begin
                    left = (w.st.body_left != '0) ? w.st.body_left - 32'd1 : '0;
                    w.st.body_left = left;
                    if (left == '0) begin
                        w.b = add_rec(w.b, KIND_BODY, w.st.slice_start,
                                      w.st.length_accum[POS_W-1:0] & {POS_W{1'b1}},
                                      '0, w.st.length_accum, w.st.flags);
                        w.b.recs[0].len = w.st.length_accum[15:0];
                        w.b = add_rec(w.b, KIND_DONE, pos, '0, '0, w.st.length_accum,
                                      w.st.flags);
                        w.st.phase = PH_DONE;
                    end
                end else if (w.st.saw_cr) begin
                    w.st.saw_cr = 1'b0;
                    if (in_byte == CH_LF) begin
                        w = proc(w, CH_LF, pos, pos - 1'b1, max_size);
                    end else begin
                        // lone CR: handle it as an ordinary byte first
                        w = proc(w, CH_CR, pos - 1'b1, pos - 1'b1, max_size);
                        if (w.st.phase != PH_DONE && w.st.phase != PH_BODY) begin
                            if (in_byte == CH_CR) begin
                                w.st.saw_cr = 1'b1;
                            end else begin
                                w = proc(w, in_byte, pos, pos, max_size);
                            end
                        end
                    end
                end else if (in_byte == CH_CR) begin
                    w.st.saw_cr = 1'b1;
                end else begin
                    w = proc(w, in_byte, pos, pos, max_size);
                end
            end
        end
        state_next = w.st;
        out_b      = w.b;
    end

    assign q_push = in_valid && in_ready && (out_b.n != '0);
    assign q_data = out_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RESET;
        end else if (in_valid && in_ready) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/hrsp_back.sv
module hrsp_back
    import hrsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_not_empty,
    input  bundle_t q_head,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_ready,
    output rec_t    out_rec,
    output logic    out_last
);
    bundle_t    entry_reg;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       take, load;

    assign out_last  = (idx_reg == entry_reg.n - 2'd1);
    assign out_rec   = entry_reg.recs[idx_reg];
    assign out_valid = busy_reg;
    assign take      = busy_reg && out_ready;
    assign load      = q_not_empty && (!busy_reg || (take && out_last));
    assign q_pop     = load;

    always_comb begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            idx_next  = '0;
            busy_next = 1'b1;
        end else if (take) begin
            if (out_last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= q_head;
        end
    end

endmodule

FILE: rtl/core/http_request_stream_parser.sv
// HTTP/1.x request parser, one request byte per input item.
// Input stream: s_axis_tdata carries the byte, s_axis_tuser high restarts
// parsing with this byte as byte 0 of a new request.
// Output stream: one item per slice record (method, path, query, version,
// header key/value, parameter key/value, headers complete, body, done,
// error); m_axis_tuser is the record kind, m_axis_tlast marks the last
// record caused by one input byte.
// APB register at address 0: max_request_size (31 bits, zero = no limit).
// Write it only while no request bytes are in flight.
// A record is registered in the queue and then in the output stage.
// Throughput: one byte per cycle while the queue has room and each byte
// yields at most one record; the output moves one record per cycle while
// m_axis_tready is high; a byte with two or three records holds it longer.
// A four-entry queue between the parser and the output stage absorbs such
// bursts and receiver stalls; s_axis_tready drops only when it is full.
// Reset clears the parse state, the queue and the register; no records are
// lost or repeated while m_axis_tready is low.
module http_request_stream_parser
    import hrsp_pkg::*;
#(
    parameter int MAX_HEADERS = DEF_MAX_HEADERS,
    parameter int MAX_PARAMS  = DEF_MAX_PARAMS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] slice_offset, [31:16] slice_length, [37:32] entry_index,
    // [69:38] content_length, [70] keep_alive, [71] expect_continue,
    // [72] body_refused, [73] headers_truncated, [74] params_truncated
    output logic [79:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast,   // is_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic REG_MAX_SIZE = 1'b0;

    logic [30:0] max_size_reg;
    logic        q_full, q_push, q_pop, q_not_empty;
    bundle_t     q_in, q_head;
    rec_t        rec;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_SIZE) ? {1'b0, max_size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_size_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_MAX_SIZE) begin
            max_size_reg <= pwdata[30:0];
        end
    end

    hrsp_front #(
        .MAX_HEADERS (MAX_HEADERS),
        .MAX_PARAMS  (MAX_PARAMS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .in_ready   (s_axis_tready),
        .max_size   (max_size_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    hrsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    hrsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_rec     (rec),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tuser = rec.kind;
    assign m_axis_tdata = {5'd0, rec.flags[FL_PTRUNC], rec.flags[FL_HTRUNC],
                           rec.flags[FL_REFUSED], rec.flags[FL_EXPECT], rec.flags[FL_KEEP],
                           rec.clen, rec.idx, rec.len, rec.off};

endmodule

FILE: rtl/core/hrsp_checker.sv
`include "http_request_stream_parser_macros.svh"

module hrsp_checker
    import hrsp_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    `HRSP_ASSERT_ALWAYS(a_idle_after_reset, !aresetn |=> !m_axis_tvalid, "record after reset")
    `HRSP_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled record changed")
    `HRSP_ASSERT(a_kind_range, m_axis_tvalid |-> m_axis_tuser <= KIND_ERROR, "bad record kind")
    `HRSP_ASSERT(a_end_last, m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ERROR) |-> m_axis_tlast, "done or error not last")

endmodule

bind http_request_stream_parser hrsp_checker u_hrsp_checker (.*);

FILE: test/tb_http_request_stream_parser.sv
`default_nettype none

import hrsp_pkg::*;

// Predicts the records of the request parser and checks them in order.
class parse_record_board;

    typedef struct {
        kind_t       kind;
        bit          last;
        logic [15:0] off;
        logic [15:0] len;
        logic [5:0]  idx;
        logic [31:0] clen;
        logic [4:0]  fl;
    } slice_rec_t;

    slice_rec_t  expected[$];
    slice_rec_t  recs[$];
    int          errors;

    int unsigned max_size;
    phase_t      ph;
    int unsigned boff, sst, qst, hcnt, pcnt, mp, bleft;
    bit          cr;
    logic [3:0]  nm;
    int          clen;
    logic [4:0]  fl;

    function new();
        max_size = 0;
        errors   = 0;
        clear_state();
    endfunction

    function void clear_state();
        ph    = PH_METHOD;
        boff  = 0;
        sst   = 0;
        qst   = 0;
        cr    = 0;
        hcnt  = 0;
        pcnt  = 0;
        nm    = NM_NONE;
        mp    = 0;
        clen  = -1;
        bleft = 0;
        fl    = 5'd1 << FL_KEEP;
    endfunction

    function void set_limit(logic [31:0] v);
        max_size = v[30:0];
    endfunction

    function void put(kind_t k, int unsigned off, int unsigned len, int unsigned idx);
        slice_rec_t r;
        if (recs.size() >= MAX_RECS) return;
        r.kind = k;
        r.last = 0;
        r.off  = off[15:0];
        r.len  = len[15:0];
        r.idx  = idx[5:0];
        r.clen = clen;
        r.fl   = fl;
        recs.push_back(r);
    endfunction

    function logic [7:0] ascii_lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function void end_query(int unsigned e);
        if (ph == PH_Q_KEY) begin
            put(KIND_PRM_KEY, sst, e - sst, pcnt);
            put(KIND_PRM_VALUE, e, 0, pcnt);
            pcnt++;
        end else if (ph == PH_Q_VAL) begin
            put(KIND_PRM_VALUE, sst, e - sst, pcnt);
            pcnt++;
        end
        put(KIND_QUERY, qst, e - qst, 0);
    endfunction

    function void query_char(logic [7:0] c, int unsigned pos);
        if (ph == PH_Q_PEND) begin
            if (pcnt >= DEF_MAX_PARAMS) begin
                fl[FL_PTRUNC] = 1;
                ph = PH_Q_SKIP;
                return;
            end
            sst = pos;
            ph  = PH_Q_KEY;
        end
        if (ph == PH_Q_KEY) begin
            if (c == CH_EQ) begin
                put(KIND_PRM_KEY, sst, pos - sst, pcnt);
                sst = pos + 1;
                ph  = PH_Q_VAL;
            end else if (c == CH_AMP) begin
                put(KIND_PRM_KEY, sst, pos - sst, pcnt);
                put(KIND_PRM_VALUE, pos, 0, pcnt);
                pcnt++;
                ph = PH_Q_PEND;
            end
        end else if (ph == PH_Q_VAL && c == CH_AMP) begin
            put(KIND_PRM_VALUE, sst, pos - sst, pcnt);
            pcnt++;
            ph = PH_Q_PEND;
        end
    endfunction

    function void match_word(string t, logic [7:0] c, logic [4:0] set_m, logic [4:0] clr_m);
        if (mp < t.len() && c == t[mp]) begin
            mp++;
            if (mp == t.len()) begin
                fl = (fl | set_m) & ~clr_m;
                nm = NM_NONE;
            end
        end else begin
            nm = NM_NONE;
        end
    endfunction

    function void value_char(logic [7:0] c);
        logic [7:0] lc;
        longint     v;
        lc = ascii_lower(c);
        case (nm)
            NM_CLEN: begin
                if (!(mp == 0 && (c == CH_SP || (c >= 8'd9 && c <= 8'd13)))) begin
                    if (mp == 0 && c == CH_PLUS) begin
                        mp = 1;
                    end else if (mp < 2 && c >= "0" && c <= "9") begin
                        v = longint'(clen) * 10 + longint'(c - 8'h30);
                        if (v > 64'sd2147483647) v = 64'sd2147483647;
                        clen = int'(v);
                        mp = 1;
                    end else begin
                        mp = 2;
                    end
                end
            end
            NM_CONN: begin
                nm = (lc == "c") ? NM_CLOSE : (lc == "k") ? NM_KEEP : NM_NONE;
                mp = 1;
            end
            NM_CLOSE:  match_word("close", lc, 5'd0, 5'd1 << FL_KEEP);
            NM_KEEP:   match_word("keep-alive", lc, 5'd1 << FL_KEEP, 5'd0);
            NM_EXPECT: match_word("100-continue", lc, 5'd1 << FL_EXPECT, 5'd0);
            default: ;
        endcase
    endfunction

    function void header_colon(int unsigned pos);
        logic [3:0] mask;
        mask = nm;
        if (hcnt >= DEF_MAX_HEADERS) begin
            fl[FL_HTRUNC] = 1;
            nm = NM_NONE;
            ph = PH_H_DROP;
            return;
        end
        put(KIND_HDR_KEY, sst, pos - sst, hcnt);
        nm = NM_NONE;
        if (mask[0] && mp == 14) begin
            nm   = NM_CLEN;
            clen = 0;
        end else if (mask[1] && mp == 10) begin
            nm = NM_CONN;
        end else if (mask[2] && mp == 6) begin
            nm = NM_EXPECT;
        end
        mp = 0;
        ph = PH_H_LEAD;
    endfunction

    function void blank_line(int unsigned pos);
        bit has_body;
        if (max_size > 0 && longint'(clen) > longint'(max_size)) begin
            fl[FL_REFUSED] = 1;
            fl[FL_KEEP]    = 0;
        end
        has_body = clen > 0 && !fl[FL_REFUSED];
        if (!has_body) fl[FL_EXPECT] = 0;
        put(KIND_HDRS_DONE, pos, 0, 0);
        if (has_body) begin
            bleft = clen;
            sst   = pos + 1;
            ph    = PH_BODY;
        end else begin
            put(KIND_DONE, pos, 0, 0);
            ph = PH_DONE;
        end
    endfunction

    function void end_value(int unsigned s, int unsigned lend);
        put(KIND_HDR_VALUE, s, lend - s, hcnt);
        hcnt++;
        nm = NM_NONE;
        ph = PH_LINE;
    endfunction

    function void parse_char(logic [7:0] c, int unsigned pos, int unsigned lend);
        bit         again;
        logic [7:0] lc;
        logic [3:0] m;
        string      hdr_name[3] = '{"content-length", "connection", "expect"};
        do begin
            again = 0;
            case (ph)
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        put(KIND_METHOD, sst, pos - sst, 0);
                        ph = PH_PRE_PATH;
                    end else if (c == CH_LF) begin
                        put(KIND_ERROR, pos, 0, 0);
                        ph = PH_DONE;
                    end
                end
                PH_PRE_PATH: begin
                    if (c == CH_LF) begin
                        put(KIND_PATH, lend, 0, 0);
                        ph = PH_LINE;
                    end else if (c != CH_SP) begin
                        sst   = pos;
                        ph    = PH_PATH;
                        again = 1;
                    end
                end
                PH_PATH: begin
                    if (c == CH_SP || c == CH_QUES) begin
                        put(KIND_PATH, sst, pos - sst, 0);
                        if (c == CH_QUES) begin
                            qst = pos + 1;
                            ph  = PH_Q_PEND;
                        end else begin
                            ph = PH_PRE_VER;
                        end
                    end else if (c == CH_LF) begin
                        put(KIND_PATH, sst, lend - sst, 0);
                        ph = PH_LINE;
                    end
                end
                PH_Q_PEND, PH_Q_KEY, PH_Q_VAL, PH_Q_SKIP: begin
                    if (c == CH_SP) begin
                        end_query(pos);
                        ph = PH_PRE_VER;
                    end else if (c == CH_LF) begin
                        end_query(lend);
                        ph = PH_LINE;
                    end else begin
                        query_char(c, pos);
                    end
                end
                PH_PRE_VER: begin
                    if (c == CH_LF) begin
                        put(KIND_VERSION, lend, 0, 0);
                        ph = PH_LINE;
                    end else if (c != CH_SP) begin
                        sst   = pos;
                        nm    = NM_VERSION;
                        mp    = 0;
                        ph    = PH_VERSION;
                        again = 1;
                    end
                end
                PH_VERSION: begin
                    if (c == CH_LF) begin
                        put(KIND_VERSION, sst, lend - sst, 0);
                        nm = NM_NONE;
                        ph = PH_LINE;
                    end else if (nm != NM_NONE) begin
                        match_word("HTTP/1.0", c, 5'd0, 5'd1 << FL_KEEP);
                    end
                end
                PH_LINE: begin
                    if (c == CH_LF) begin
                        blank_line(pos);
                    end else begin
                        sst   = pos;
                        nm    = NM_ALL;
                        mp    = 0;
                        ph    = PH_H_KEY;
                        again = 1;
                    end
                end
                PH_H_KEY: begin
                    if (c == CH_COLON) begin
                        header_colon(pos);
                    end else if (c == CH_LF) begin
                        put(KIND_ERROR, pos, 0, 0);
                        ph = PH_DONE;
                    end else begin
                        lc = ascii_lower(c);
                        m  = nm;
                        for (int i = 0; i < 3; i++)
                            if (mp >= hdr_name[i].len() || lc != hdr_name[i][mp]) m[i] = 0;
                        nm = m;
                        if (mp < 15) mp++;
                    end
                end
                PH_H_LEAD: begin
                    if (c == CH_LF) begin
                        end_value(lend, lend);
                    end else if (c != CH_SP && c != CH_TAB) begin
                        sst   = pos;
                        ph    = PH_H_VALUE;
                        again = 1;
                    end
                end
                PH_H_VALUE: begin
                    if (c == CH_LF) end_value(sst, lend);
                    else value_char(c);
                end
                PH_H_DROP: begin
                    if (c == CH_LF) ph = PH_LINE;
                end
                default: ;
            endcase
        end while (again);
    endfunction

    // Note an accepted byte and queue the records it should cause.
    function void note_byte(logic [7:0] c, bit rs);
        int unsigned pos;
        recs.delete();
        if (rs) clear_state();
        if (ph != PH_DONE) begin
            if (boff >= 32'h10000) begin
                put(KIND_ERROR, boff, 0, 0);
                ph = PH_DONE;
                cr = 0;
            end else begin
                pos = boff;
                boff++;
                if (ph == PH_BODY) begin
                    if (bleft > 0) bleft--;
                    if (bleft == 0) begin
                        put(KIND_BODY, sst, clen, 0);
                        put(KIND_DONE, pos, 0, 0);
                        ph = PH_DONE;
                    end
                end else if (cr) begin
                    cr = 0;
                    if (c == CH_LF) begin
                        parse_char(c, pos, pos - 1);
                    end else begin
                        // a lone CR counts as a character of its own
                        parse_char(CH_CR, pos - 1, pos - 1);
                        if (ph != PH_DONE && ph != PH_BODY) begin
                            if (c == CH_CR) cr = 1;
                            else parse_char(c, pos, pos);
                        end
                    end
                end else if (c == CH_CR) begin
                    cr = 1;
                end else begin
                    parse_char(c, pos, pos);
                end
            end
        end
        if (recs.size() > 0) recs[recs.size()-1].last = 1;
        foreach (recs[i]) expected.push_back(recs[i]);
    endfunction

    function void cmp(string field, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, e, a);
            errors++;
        end
    endfunction

    function void check_record(logic [3:0] kind, logic last, logic [79:0] d);
        slice_rec_t r;
        if (expected.size() == 0) begin
            $error("unexpected record of kind %0d", kind);
            errors++;
            return;
        end
        r = expected.pop_front();
        cmp("kind", r.kind, kind);
        cmp("is_last", r.last, last);
        cmp("slice_offset", r.off, d[15:0]);
        cmp("slice_length", r.len, d[31:16]);
        cmp("entry_index", r.idx, d[37:32]);
        cmp("content_length", r.clen, d[69:38]);
        cmp("keep_alive", r.fl[FL_KEEP], d[70]);
        cmp("expect_continue", r.fl[FL_EXPECT], d[71]);
        cmp("body_refused", r.fl[FL_REFUSED], d[72]);
        cmp("headers_truncated", r.fl[FL_HTRUNC], d[73]);
        cmp("params_truncated", r.fl[FL_PTRUNC], d[74]);
    endfunction
endclass

module tb_http_request_stream_parser;
    import hrsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [79:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    parse_record_board board;
    int  burst_left = 0;
    int  idle_cycles = 0;
    int  rx_cycle = 0;
    int  rx_mode = 0;
    bit  rx_hold = 0;
    bit  hold_go = 0;

    http_request_stream_parser u_dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // Receiver: back-pressure pattern that changes mode every so often.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 97 == 0) rx_mode <= $urandom_range(0, 2);
        if (rx_hold)           m_axis_tready <= 0;
        else if (rx_mode == 0) m_axis_tready <= 1;
        else if (rx_mode == 1) m_axis_tready <= ($urandom_range(0, 99) < 60);
        else                   m_axis_tready <= (rx_cycle % 8 != 0);
    end

    // Hold the receiver off for a long stretch while the sender keeps going.
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1;
        repeat (60) @(posedge aclk);
        rx_hold <= 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_record(m_axis_tuser, m_axis_tlast, m_axis_tdata);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, bit rs);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rs;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_byte(b, rs);
    endtask

    task automatic send_text(string t);
        for (int i = 0; i < t.len(); i++) send_byte(t[i], i == 0);
    endtask

    // Pause the sender until every record has come, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (board.expected.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_limit(logic [31:0] v);
        drain();
        psel    <= 1;
        pwrite  <= 1;
        penable <= 0;
        paddr   <= 0;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        board.set_limit(v);
        psel    <= 0;
        penable <= 0;
    endtask

    initial begin
        string t;
        board = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        set_limit(32'd0);
        hold_go = 1;
        send_text({"GET /a?k=v&f&=x HTTP/1.0\r\nContent-Length: +3\r\n",
                   "Expect: 100-continue\r\n\r\nxyz"});
        send_text("P\n");
        send_text("X  /p\r\nbad line\n");
        send_text("G \r\rq\n\n");
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        t = "G /?";
        for (int i = 0; i < 17; i++) t = {t, "&"};
        send_text({t, " H\n\n"});

        // saturated length over a small limit: refused
        set_limit(32'd5);
        send_text("P /\ncontent-length:99999999999\n\n");

        for (int i = 0; i < 12; i++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        s_axis_tvalid <= 0;
        while (board.expected.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.errors == 0 && board.expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/hrsp_pkg.sv
rtl/core/hrsp_queue.sv
rtl/core/hrsp_front.sv
rtl/core/hrsp_back.sv
rtl/core/http_request_stream_parser.sv
rtl/core/hrsp_checker.sv
test/tb_http_request_stream_parser.sv
